// ----- rtl/core/dsms_pkg.sv -----
// Shared types and constants for the dynamic sequence maximum-subarray block.
// Holds the transfer payload structs, operation and status codes, and parameter defaults.
// No dependencies.
`default_nettype none

package dsms_pkg;

    localparam int DEPTH_DEFAULT      = 1024;
    localparam int VALUE_BITS_DEFAULT = 16;

    localparam int POS_W      = 11;
    localparam int IN_VALUE_W = 16;
    localparam int SUM_W      = 26;
    localparam int LEN_W      = 11;

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_REPLACE = 2'd1;
    localparam logic [1:0] MODE_DELETE  = 2'd2;
    localparam logic [1:0] MODE_QUERY   = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_OUT_RANGE = 2'd2;
    localparam logic [1:0] STATUS_BAD_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]                   mode;
        logic [POS_W-1:0]             position;
        logic [POS_W-1:0]             position_end;
        logic signed [IN_VALUE_W-1:0] value;
    } dsms_req_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] best_sum;
        logic [1:0]              status;
        logic [LEN_W-1:0]        current_length;
    } dsms_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/dsms_stream_if.sv -----
// Valid/ready stream interface with a typed payload.
// Source drives valid and payload, sink drives ready. No dependencies.
`default_nettype none

interface dsms_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dsms_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module dsms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dsms_accum.sv -----
// Running maximum-subarray accumulator: one add and one compare per step.
// Stepped once per element by the sequencer in the top level. No dependencies.
`default_nettype none

module dsms_accum #(
    parameter int VALUE_BITS = 16,
    parameter int ACC_W      = 27
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         clear,
    input  wire logic                         step,
    input  wire logic signed [VALUE_BITS-1:0] x,
    output      logic signed [ACC_W-1:0]      best
);

    logic                    first_reg;
    logic signed [ACC_W-1:0] cur_reg;
    logic signed [ACC_W-1:0] best_reg;
    logic signed [ACC_W-1:0] x_ext;
    logic signed [ACC_W-1:0] sum;
    logic                    cur_pos;
    logic signed [ACC_W-1:0] cur_next;
    logic signed [ACC_W-1:0] best_next;

    assign x_ext   = ACC_W'(x);
    assign sum     = cur_reg + x_ext;
    assign cur_pos = !cur_reg[ACC_W-1] && (cur_reg != '0);

    always_comb
    begin
        if (first_reg)
        begin
            cur_next  = x_ext;
            best_next = x_ext;
        end
        else
        begin
            cur_next  = cur_pos ? sum : x_ext;
            best_next = (cur_next > best_reg) ? cur_next : best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            cur_reg   <= '0;
            best_reg  <= '0;
        end
        else if (clear)
        begin
            first_reg <= 1'b1;
        end
        else if (step)
        begin
            first_reg <= 1'b0;
            cur_reg   <= cur_next;
            best_reg  <= best_next;
        end
    end

    assign best = best_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dynamic_sequence_max_subarray.sv -----
// Ordered sequence store with insert, replace, delete and maximum-subarray range query.
// Depends on dsms_pkg, dsms_stream_if, dsms_ram and dsms_accum.
//
// req carries one operation per transfer; rsp returns exactly one result per operation,
// in order. The element store is a single RAM with one read and one write port; a
// pipelined read/write sequencer moves one element per cycle through it, and the
// accumulator takes one element per cycle during a query.
// Steps from request transfer to result ready:
//   insert   shift elements from the slot on up by one, then write; an append only writes
//   delete   shift the later elements down by one; removing the last one only drops it
//   query    feed elements position..position_end to the accumulator
//   replace  write the value in place; an error status goes straight to the result
// req.ready is high only while the sequencer is idle, so a request waits until the
// previous one is done; the element shift through the RAM port makes the worst case.
// A finished result waits in the output register; the next request is taken meanwhile,
// and its result is held in the sequencer until rsp accepts the previous one.
// Reset empties the sequence at once; no clearing pass runs over the RAM.
`default_nettype none

module dynamic_sequence_max_subarray #(
    parameter int DEPTH      = dsms_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = dsms_pkg::VALUE_BITS_DEFAULT
) (
    input wire logic       clk,
    input wire logic       rst_n,
    dsms_stream_if.sink    req,
    dsms_stream_if.source  rsp
);

    import dsms_pkg::*;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;
    localparam int ACC_W   = VALUE_BITS + $clog2(DEPTH) + 1;
    localparam int SAT_W   = (ACC_W > SUM_W) ? ACC_W : SUM_W;

    localparam logic signed [SAT_W-1:0] SUM_HI = SAT_W'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] SUM_LO = ~SUM_HI;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_SCAN,
        S_PUT,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]       ptr_reg, ptr_next;
    logic [ADDR_W-1:0]       lim_reg, lim_next;
    logic                    issue_reg, issue_next;
    logic                    pipe_valid_reg, pipe_valid_next;
    logic [ADDR_W-1:0]       pipe_addr_reg, pipe_addr_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic                    grow_reg, grow_next;
    logic [1:0]              status_reg, status_next;
    logic                    query_ok_reg, query_ok_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    dsms_rsp_t               rsp_data_reg, rsp_data_next;

    logic [CMP_W-1:0]        pos_w;
    logic [CMP_W-1:0]        pend_w;
    logic [CMP_W-1:0]        cnt_w;
    logic [CMP_W-1:0]        pos_m1;
    logic [CMP_W-1:0]        pend_m1;
    logic [CMP_W-1:0]        cnt_m1;
    logic [CMP_W-1:0]        k_w;
    logic [31:0]             value_ext;
    logic [VALUE_BITS-1:0]   value_raw;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [VALUE_BITS-1:0]   mem_wdata;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [VALUE_BITS-1:0]   mem_rdata;

    logic                    acc_clear;
    logic                    acc_step;
    logic signed [ACC_W-1:0] acc_best;
    logic signed [SAT_W-1:0] best_wide;
    logic signed [SAT_W-1:0] best_clamped;
    logic                    in_transfer;

    dsms_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dsms_accum #(
        .VALUE_BITS (VALUE_BITS),
        .ACC_W      (ACC_W)
    ) u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (acc_clear),
        .step  (acc_step),
        .x     (signed'(mem_rdata)),
        .best  (acc_best)
    );

    assign in_transfer = req.valid && req.ready;

    assign pos_w     = CMP_W'(req.payload.position);
    assign pend_w    = CMP_W'(req.payload.position_end);
    assign cnt_w     = CMP_W'(count_reg);
    assign pos_m1    = pos_w - CMP_W'(1);
    assign pend_m1   = pend_w - CMP_W'(1);
    assign cnt_m1    = cnt_w - CMP_W'(1);
    assign k_w       = (pos_m1 > cnt_w) ? cnt_w : pos_m1;
    assign value_ext = {{(32 - IN_VALUE_W){1'b0}}, req.payload.value};
    assign value_raw = value_ext[VALUE_BITS-1:0];

    assign best_wide = SAT_W'(acc_best);

    always_comb
    begin
        if (best_wide > SUM_HI)
        begin
            best_clamped = SUM_HI;
        end
        else if (best_wide < SUM_LO)
        begin
            best_clamped = SUM_LO;
        end
        else
        begin
            best_clamped = best_wide;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        lim_next        = lim_reg;
        issue_next      = issue_reg;
        pipe_valid_next = pipe_valid_reg;
        pipe_addr_next  = pipe_addr_reg;
        val_next        = val_reg;
        grow_next       = grow_reg;
        status_next     = status_reg;
        query_ok_next   = query_ok_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_data_next   = rsp_data_reg;

        mem_we    = 1'b0;
        mem_waddr = pipe_addr_reg;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = ptr_reg;
        acc_clear = 1'b0;
        acc_step  = 1'b0;

        // advance the read/write pipeline while walking the store
        if (state_reg == S_SHIFT_UP || state_reg == S_SHIFT_DOWN || state_reg == S_SCAN)
        begin
            mem_re          = issue_reg;
            pipe_valid_next = issue_reg;
            pipe_addr_next  = ptr_reg;
            if (issue_reg)
            begin
                if (ptr_reg == lim_reg)
                begin
                    issue_next = 1'b0;
                end
                else if (state_reg == S_SHIFT_UP)
                begin
                    ptr_next = ptr_reg - ADDR_W'(1);
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    val_next        = value_raw;
                    status_next     = STATUS_OK;
                    query_ok_next   = 1'b0;
                    pipe_valid_next = 1'b0;
                    issue_next      = 1'b0;
                    state_next      = S_DONE;
                    case (req.payload.mode)
                        MODE_INSERT:
                        begin
                            if (count_reg == COUNT_W'(DEPTH))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else if (pos_w == '0)
                            begin
                                status_next = STATUS_OUT_RANGE;
                            end
                            else
                            begin
                                grow_next = 1'b1;
                                lim_next  = k_w[ADDR_W-1:0];
                                if (k_w == cnt_w)
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    ptr_next   = cnt_m1[ADDR_W-1:0];
                                    issue_next = 1'b1;
                                    state_next = S_SHIFT_UP;
                                end
                            end
                        end
                        MODE_REPLACE:
                        begin
                            if (pos_w == '0 || pos_w > cnt_w)
                            begin
                                status_next = STATUS_OUT_RANGE;
                            end
                            else
                            begin
                                grow_next  = 1'b0;
                                lim_next   = pos_m1[ADDR_W-1:0];
                                state_next = S_PUT;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (pos_w == '0 || pos_w > cnt_w)
                            begin
                                status_next = STATUS_OUT_RANGE;
                            end
                            else if (pos_w == cnt_w)
                            begin
                                count_next = count_reg - COUNT_W'(1);
                            end
                            else
                            begin
                                ptr_next   = pos_w[ADDR_W-1:0];
                                lim_next   = cnt_m1[ADDR_W-1:0];
                                issue_next = 1'b1;
                                state_next = S_SHIFT_DOWN;
                            end
                        end
                        default:
                        begin
                            if (pos_w == '0 || pend_w > cnt_w || pos_w > pend_w)
                            begin
                                status_next = STATUS_BAD_RANGE;
                            end
                            else
                            begin
                                ptr_next      = pos_m1[ADDR_W-1:0];
                                lim_next      = pend_m1[ADDR_W-1:0];
                                issue_next    = 1'b1;
                                query_ok_next = 1'b1;
                                acc_clear     = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                mem_we    = pipe_valid_reg;
                mem_waddr = pipe_addr_reg + ADDR_W'(1);
                if (!issue_reg && !pipe_valid_reg)
                begin
                    state_next = S_PUT;
                end
            end
            S_SHIFT_DOWN:
            begin
                mem_we    = pipe_valid_reg;
                mem_waddr = pipe_addr_reg - ADDR_W'(1);
                if (!issue_reg && !pipe_valid_reg)
                begin
                    count_next = count_reg - COUNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                acc_step = pipe_valid_reg;
                if (!issue_reg && !pipe_valid_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = lim_reg;
                mem_wdata = val_reg;
                if (grow_reg)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next               = 1'b1;
                    rsp_data_next.best_sum       = query_ok_reg ? best_clamped[SUM_W-1:0] : '0;
                    rsp_data_next.status         = status_reg;
                    rsp_data_next.current_length = LEN_W'(count_reg);
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            lim_reg        <= '0;
            issue_reg      <= 1'b0;
            pipe_valid_reg <= 1'b0;
            pipe_addr_reg  <= '0;
            val_reg        <= '0;
            grow_reg       <= 1'b0;
            status_reg     <= STATUS_OK;
            query_ok_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            lim_reg        <= lim_next;
            issue_reg      <= issue_next;
            pipe_valid_reg <= pipe_valid_next;
            pipe_addr_reg  <= pipe_addr_next;
            val_reg        <= val_next;
            grow_reg       <= grow_next;
            status_reg     <= status_next;
            query_ok_reg   <= query_ok_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_data_reg   <= rsp_data_next;
        end
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("element count exceeds store depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + COUNT_W'(1) ||
             count_reg + COUNT_W'(1) == $past(count_reg)))
        else $error("element count changed by more than one");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (COUNT_W'(mem_waddr) <= count_reg))
        else $error("store write beyond the sequence end");

    a_error_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.status != STATUS_OK) |-> (rsp_data_reg.best_sum == '0))
        else $error("nonzero sum on an error result");

    a_accept_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_transfer |-> (!issue_reg && !pipe_valid_reg))
        else $error("request taken while the store pipeline is busy");

endmodule

`default_nettype wire
